// File: rtl/bsrd_pkg.sv
package bsrd_pkg;

    // Item codes
    localparam logic [2:0] OP_READ_WORD  = 3'd0;
    localparam logic [2:0] OP_WRITE_WORD = 3'd1;
    localparam logic [2:0] OP_WRITE_BYTE = 3'd2;
    localparam logic [2:0] OP_LOAD_PAGE  = 3'd3;
    localparam logic [2:0] OP_LOAD_HNDL  = 3'd4;
    localparam logic [2:0] OP_LOAD_VALUE = 3'd5;
    localparam logic [2:0] OP_LOAD_MASK  = 3'd6;
    localparam logic [2:0] OP_LOAD_EVENT = 3'd7;

    // Result routes
    localparam logic [1:0] ROUTE_NONE = 2'd0;
    localparam logic [1:0] ROUTE_MEM  = 2'd1;
    localparam logic [1:0] ROUTE_DEV  = 2'd2;
    localparam logic [1:0] ROUTE_LOAD = 2'd3;

    // Event notice kinds
    localparam logic [1:0] EVK_NONE  = 2'd0;
    localparam logic [1:0] EVK_DATI  = 2'd1;
    localparam logic [1:0] EVK_DATO  = 2'd2;
    localparam logic [1:0] EVK_DATOB = 2'd3;

    // Page kinds
    localparam logic [1:0] KIND_MEM = 2'd1;
    localparam logic [1:0] KIND_IO  = 2'd2;

    // Event flag bits
    localparam int EV_DATI_BIT = 0;
    localparam int EV_DATO_BIT = 1;

    localparam logic [15:0] LANE_LO = 16'h00ff;
    localparam logic [15:0] LANE_HI = 16'hff00;

    typedef struct packed {
        logic [2:0]  op;
        logic [17:0] addr;
        logic [15:0] data;
        logic [11:0] table_index;
        logic [15:0] table_value;
    } item_t;

    typedef struct packed {
        logic [1:0]  route;
        logic [15:0] read_data;
        logic [15:0] write_value;
        logic        byte_access;
        logic [1:0]  event_kind;
        logic [7:0]  event_handle;
    } result_t;

    // One register entry as held in the register RAM
    typedef struct packed {
        logic [15:0] value;
        logic [15:0] mask;
        logic [1:0]  flags;
    } regent_t;

endpackage

// File: rtl/bsrd_stream_if.sv
interface bsrd_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/bsrd_ram.sv
module bsrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// File: rtl/bus_slave_register_decoder_unit.sv
// Channel  Dir  Payload                                              Handshake
// req      in   op, addr, data, table_index, table_value            valid/ready
// rsp      out  route, read_data, write_value, byte_access,         valid/ready
//               event_kind, event_handle
//
// One item at a time, in a chain of states: page and handle loads write the map
// RAM; register loads read, then write the register RAM entry; memory or unmapped
// accesses read the page kind from the map RAM, I/O accesses then read the handle,
// and if the handle selects a register, read and (for writes) rewrite its entry
// in the register RAM.
// After reset the map RAM is zeroed in a pass over all IO_WORDS + NUM_PAGES entries
// with req.ready low; register entries use per-entry valid bits instead.
// A finished item waits in its last state while the result register is full and rsp.ready is low.
module bus_slave_register_decoder_unit #(
    parameter int NUM_PAGES = 32,
    parameter int IO_WORDS  = 4096,
    parameter int NUM_REGS  = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    bsrd_stream_if.sink   req,
    bsrd_stream_if.source rsp
);
    import bsrd_pkg::*;

    // Map RAM holds handle_map at 0.. and page_map at IO_WORDS..
    localparam int DA = IO_WORDS + NUM_PAGES;
    localparam int AW = $clog2(DA);
    localparam int PB = $clog2(NUM_PAGES);
    localparam int RB = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int RW = $bits(regent_t);
    // Reciprocal for the word index modulo IO_WORDS (exact for 17-bit words)
    localparam int QS = 30;
    localparam logic [22:0] RECIP = 23'(((64'd1 << QS) + 64'(IO_WORDS) - 64'd1)
                                        / 64'(IO_WORDS));

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_PAGE, S_KIND, S_HANDLE, S_REG, S_LOAD, S_LREAD, S_LWRITE
    } state_t;

    state_t        state_reg;
    item_t         item_reg;
    logic [9:0]    q_reg;
    logic [7:0]    h_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic          ovalid_reg;
    result_t       res_reg;
    logic [NUM_REGS-1:0] valid_reg;

    logic          ra_we, ra_re;
    logic [AW-1:0] ra_waddr, ra_raddr;
    logic [7:0]    ra_wdata, ra_rdata;
    logic          rb_we, rb_re;
    logic [RB-1:0] rb_waddr, rb_raddr;
    regent_t       rb_wdata, rb_rdata, rb_cur;

    logic          fire, fin;
    result_t       res_next;
    logic [26:0]   page_prod;
    logic [PB-1:0] page;
    logic [39:0]   q_prod;
    logic [16:0]   word_x, word_full;
    logic [15:0]   nv, byte_ext;
    logic          tidx_page_ok, tidx_word_ok, tidx_reg_ok, h_bad;

    bsrd_ram #(.WIDTH(8), .DEPTH(DA)) u_map_ram (
        .clk   (clk),
        .we    (ra_we),
        .waddr (ra_waddr),
        .wdata (ra_wdata),
        .re    (ra_re),
        .raddr (ra_raddr),
        .rdata (ra_rdata)
    );

    bsrd_ram #(.WIDTH(RW), .DEPTH(NUM_REGS)) u_reg_ram (
        .clk   (clk),
        .we    (rb_we),
        .waddr (rb_waddr),
        .wdata (rb_wdata),
        .re    (rb_re),
        .raddr (rb_raddr),
        .rdata (rb_rdata)
    );

    // Address decode arithmetic
    assign page_prod = 27'(item_reg.addr) * 27'(NUM_PAGES);
    assign page      = page_prod[18 +: PB];
    assign word_x    = item_reg.addr[17:1];
    assign q_prod    = 40'(word_x) * 40'(RECIP);
    assign word_full = word_x - 17'(23'(q_reg) * 23'(IO_WORDS));

    assign tidx_page_ok = 13'(item_reg.table_index) < 13'(NUM_PAGES);
    assign tidx_word_ok = 13'(item_reg.table_index) < 13'(IO_WORDS);
    assign tidx_reg_ok  = 13'(item_reg.table_index) < 13'(NUM_REGS);
    assign h_bad        = (ra_rdata == 8'd0) || (9'(ra_rdata) >= 9'(NUM_REGS));

    // Register entry that was never written reads as zero
    assign rb_cur   = (state_reg == S_REG) ? (valid_reg[h_reg[RB-1:0]] ? rb_rdata : '0)
                                           : (valid_reg[item_reg.table_index[RB-1:0]]
                                              ? rb_rdata : '0);
    assign byte_ext = {8'h00, item_reg.data[7:0]};

    assign fire      = !ovalid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid   = ovalid_reg;
    assign rsp.payload = res_reg;

    // Memory controls and result of the finishing step
    always_comb
    begin
        ra_we    = 1'b0;
        ra_re    = 1'b0;
        ra_waddr = '0;
        ra_raddr = '0;
        ra_wdata = '0;
        rb_we    = 1'b0;
        rb_re    = 1'b0;
        rb_waddr = '0;
        rb_raddr = '0;
        rb_wdata = rb_cur;
        fin      = 1'b0;
        res_next = '0;
        nv       = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ra_we    = 1'b1;
                ra_waddr = clr_cnt_reg;
            end
            S_IDLE:
            begin
            end
            S_PAGE:
            begin
                ra_re    = 1'b1;
                ra_raddr = AW'(IO_WORDS) + AW'(page);
            end
            S_KIND:
            begin
                if (ra_rdata[1:0] == KIND_IO)
                begin
                    ra_re    = 1'b1;
                    ra_raddr = AW'(word_full);
                end
                else
                begin
                    fin = 1'b1;
                    if (ra_rdata[1:0] == KIND_MEM)
                    begin
                        res_next.route = ROUTE_MEM;
                        if (item_reg.op == OP_WRITE_WORD)
                        begin
                            res_next.write_value = item_reg.data;
                        end
                        else if (item_reg.op == OP_WRITE_BYTE)
                        begin
                            res_next.write_value = byte_ext;
                            res_next.byte_access = 1'b1;
                        end
                    end
                end
            end
            S_HANDLE:
            begin
                if (h_bad)
                begin
                    fin = 1'b1;
                end
                else
                begin
                    rb_re    = 1'b1;
                    rb_raddr = ra_rdata[RB-1:0];
                end
            end
            S_REG:
            begin
                fin            = 1'b1;
                res_next.route = ROUTE_DEV;
                if (item_reg.op == OP_READ_WORD)
                begin
                    res_next.read_data = rb_cur.value;
                    if (rb_cur.flags[EV_DATI_BIT])
                    begin
                        res_next.event_kind   = EVK_DATI;
                        res_next.event_handle = h_reg;
                    end
                end
                else
                begin
                    if (item_reg.op == OP_WRITE_WORD)
                    begin
                        nv = (rb_cur.value & ~rb_cur.mask) | (item_reg.data & rb_cur.mask);
                    end
                    else if (item_reg.addr[0])
                    begin
                        // odd address: upper lane
                        nv = (rb_cur.value & LANE_LO)
                           | (rb_cur.value & ~rb_cur.mask & LANE_HI)
                           | ({byte_ext[7:0], 8'h00} & rb_cur.mask);
                    end
                    else
                    begin
                        nv = (rb_cur.value & LANE_HI)
                           | (rb_cur.value & ~rb_cur.mask & LANE_LO)
                           | (byte_ext & rb_cur.mask);
                    end
                    res_next.write_value = nv;
                    if (rb_cur.flags[EV_DATO_BIT])
                    begin
                        res_next.event_kind   = (item_reg.op == OP_WRITE_WORD) ? EVK_DATO
                                                                               : EVK_DATOB;
                        res_next.event_handle = h_reg;
                    end
                    rb_we          = fire;
                    rb_waddr       = h_reg[RB-1:0];
                    rb_wdata.value = nv;
                end
            end
            S_LOAD:
            begin
                fin            = 1'b1;
                res_next.route = ROUTE_LOAD;
                if (item_reg.op == OP_LOAD_PAGE)
                begin
                    ra_we    = fire && tidx_page_ok;
                    ra_waddr = AW'(IO_WORDS) + AW'(item_reg.table_index);
                    ra_wdata = {6'd0, item_reg.table_value[1:0]};
                end
                else
                begin
                    ra_we    = fire && tidx_word_ok;
                    ra_waddr = AW'(item_reg.table_index);
                    ra_wdata = item_reg.table_value[7:0];
                end
            end
            S_LREAD:
            begin
                rb_re    = tidx_reg_ok;
                rb_raddr = item_reg.table_index[RB-1:0];
            end
            S_LWRITE:
            begin
                fin            = 1'b1;
                res_next.route = ROUTE_LOAD;
                rb_we          = fire && tidx_reg_ok;
                rb_waddr       = item_reg.table_index[RB-1:0];
                priority case (item_reg.op)
                    OP_LOAD_VALUE: rb_wdata.value = item_reg.table_value;
                    OP_LOAD_MASK:  rb_wdata.mask  = item_reg.table_value;
                    default:       rb_wdata.flags = item_reg.table_value[1:0];
                endcase
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            if (fin && fire)
            begin
                ovalid_reg <= 1'b1;
                res_reg    <= res_next;
                state_reg  <= S_IDLE;
            end
            else
            begin
                if (ovalid_reg && rsp.ready)
                begin
                    ovalid_reg <= 1'b0;
                end
                unique case (state_reg)
                    S_CLEAR:
                    begin
                        clr_cnt_reg <= clr_cnt_reg + 1'b1;
                        if (clr_cnt_reg == AW'(DA - 1))
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    S_IDLE:
                    begin
                        if (req.valid)
                        begin
                            item_reg <= req.payload;
                            if (req.payload.op == OP_READ_WORD ||
                                req.payload.op == OP_WRITE_WORD ||
                                req.payload.op == OP_WRITE_BYTE)
                            begin
                                state_reg <= S_PAGE;
                            end
                            else if (req.payload.op == OP_LOAD_PAGE ||
                                     req.payload.op == OP_LOAD_HNDL)
                            begin
                                state_reg <= S_LOAD;
                            end
                            else
                            begin
                                state_reg <= S_LREAD;
                            end
                        end
                    end
                    S_PAGE:
                    begin
                        q_reg     <= q_prod[QS +: 10];
                        state_reg <= S_KIND;
                    end
                    S_KIND:
                    begin
                        if (ra_rdata[1:0] == KIND_IO)
                        begin
                            state_reg <= S_HANDLE;
                        end
                    end
                    S_HANDLE:
                    begin
                        h_reg <= ra_rdata;
                        if (!h_bad)
                        begin
                            state_reg <= S_REG;
                        end
                    end
                    S_LREAD:
                    begin
                        state_reg <= S_LWRITE;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Register entry valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (rb_we)
        begin
            valid_reg[rb_waddr] <= 1'b1;
        end
    end

    // Checks
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg != S_IDLE))
        else $error("accepted item did not start");

    a_clear_writes_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (ra_we && ra_wdata == 8'd0 && !req.ready))
        else $error("clearing pass broken");

    a_clear_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg) == S_CLEAR && state_reg != S_CLEAR) |-> (state_reg == S_IDLE))
        else $error("clearing pass left to wrong state");

    a_reg_write_valid: assert property (@(posedge clk) disable iff (!rst_n)
        rb_we |=> valid_reg[$past(rb_waddr)])
        else $error("written register entry not marked valid");

    a_write_once: assert property (@(posedge clk) disable iff (!rst_n)
        rb_we |=> !rb_we)
        else $error("register entry written twice for one item");
endmodule
